// File: rtl/ple_pkg.sv
// Package for the positional list engine: request/response payload types,
// operation and status codes, and the controller state type.
// No dependencies.
package ple_pkg;

   // operation codes carried in the request
   localparam logic [2:0] OP_INS_FRONT = 3'd0;
   localparam logic [2:0] OP_INS_BACK  = 3'd1;
   localparam logic [2:0] OP_INS_POS   = 3'd2;
   localparam logic [2:0] OP_DEL_POS   = 3'd3;
   localparam logic [2:0] OP_READ_OUT  = 3'd4;

   // response status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_BADPOS = 2'd1;
   localparam logic [1:0] ST_EMPTY  = 2'd2;
   localparam logic [1:0] ST_FULL   = 2'd3;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [31:0] value;
      logic [4:0]         position;
   } ple_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] element;
      logic [4:0]         count;
      logic               last;
   } ple_rsp_type;

   // commands from controller to datapath
   typedef struct packed {
      logic latch;   // capture the incoming request
      logic exec;    // apply the captured operation
      logic step;    // emit one element of a read out
   } ple_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic out_free;   // response register can take a new response
      logic read_go;    // captured request is a read out of a non-empty list
      logic read_last;  // next read out step emits the final element
   } ple_stat_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_READ
   } ple_state_type;

endpackage

// File: rtl/ple_ctrl.sv
// Controller for the positional list engine: accept / execute / read out
// sequencing. Depends on ple_pkg.
module ple_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ple_pkg::ple_stat_type stat,
   output ple_pkg::ple_cmd_type  cmd
);
   import ple_pkg::*;

   ple_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            // wait for the response register before touching the list
            if (stat.out_free) begin
               cmd.exec = 1'b1;
               state_in = stat.read_go ? S_READ : S_IDLE;
            end
         end
         S_READ: begin
            if (stat.out_free) begin
               cmd.step = 1'b1;
               if (stat.read_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/ple_datapath.sv
// Datapath for the positional list engine: request register, row of shifting
// cells, element count, read out counter and response register. Depends on ple_pkg.
module ple_datapath #(
   parameter int CAPACITY = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ple_pkg::ple_req_type  req_data,
   input  ple_pkg::ple_cmd_type  cmd,
   output ple_pkg::ple_stat_type stat,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output ple_pkg::ple_rsp_type  rsp_data
);
   import ple_pkg::*;

   localparam int LW = $clog2(CAPACITY + 1);
   localparam int CW = ((LW > 5) ? LW : 5) + 1;

   ple_req_type        req_ff;
   logic [LW-1:0]      len_ff, len_in;
   logic [LW-1:0]      rd_left_ff, rd_left_in;
   logic signed [31:0] cell_ff [CAPACITY];
   logic signed [31:0] cell_in [CAPACITY];
   ple_rsp_type        rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [CW-1:0] pos_ext, len_ext, ins_idx, del_idx;
   logic          is_ins, full, ins_bad, del_empty, del_bad;
   logic          do_ins, do_del, known_op, exec_load;
   logic [1:0]    exec_status;

   // operation decode against the current count
   always_comb begin
      pos_ext   = CW'(req_ff.position);
      len_ext   = CW'(len_ff);
      is_ins    = (req_ff.opcode == OP_INS_FRONT) || (req_ff.opcode == OP_INS_BACK) ||
                  (req_ff.opcode == OP_INS_POS);
      known_op  = is_ins || (req_ff.opcode == OP_DEL_POS) || (req_ff.opcode == OP_READ_OUT);
      full      = (len_ext >= CW'(CAPACITY));
      ins_bad   = (req_ff.opcode == OP_INS_POS) &&
                  ((pos_ext == '0) || (pos_ext > len_ext + CW'(1)));
      del_empty = (len_ext == '0);
      del_bad   = (pos_ext == '0) || (pos_ext > len_ext);
      do_ins    = is_ins && !full && !ins_bad;
      do_del    = (req_ff.opcode == OP_DEL_POS) && !del_empty && !del_bad;
      del_idx   = pos_ext - CW'(1);
      unique case (req_ff.opcode)
         OP_INS_FRONT: ins_idx = '0;
         OP_INS_BACK:  ins_idx = len_ext;
         default:      ins_idx = pos_ext - CW'(1);
      endcase
      stat.read_go   = (req_ff.opcode == OP_READ_OUT) && !del_empty;
      stat.read_last = (rd_left_ff == LW'(1));
      stat.out_free  = !rsp_valid_ff || !rsp_stall;
      exec_load      = cmd.exec && known_op && !stat.read_go;
   end

   // status of a single-response operation, full tested before position
   always_comb begin
      priority if (is_ins && full) begin
         exec_status = ST_FULL;
      end else if (is_ins && ins_bad) begin
         exec_status = ST_BADPOS;
      end else if (!is_ins && del_empty) begin
         exec_status = ST_EMPTY;
      end else if (!is_ins && del_bad) begin
         exec_status = ST_BADPOS;
      end else begin
         exec_status = ST_OK;
      end
   end

   // count and read out counter
   always_comb begin
      len_in = len_ff;
      if (cmd.exec && do_ins) begin
         len_in = len_ff + LW'(1);
      end else if (cmd.exec && do_del) begin
         len_in = len_ff - LW'(1);
      end
      rd_left_in = rd_left_ff;
      if (cmd.exec && stat.read_go) begin
         rd_left_in = len_ff;
      end else if (cmd.step) begin
         rd_left_in = rd_left_ff - LW'(1);
      end
   end

   // row of cells: shift up on insert, down on delete, rotate on read out
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam int PREV = (i > 0) ? i - 1 : 0;
      localparam int NEXT = (i < CAPACITY - 1) ? i + 1 : i;
      localparam logic [CW-1:0] IDX = CW'(i);
      localparam logic [CW-1:0] IDX1 = CW'(i + 1);

      always_comb begin
         cell_in[i] = cell_ff[i];
         if (cmd.exec && do_ins) begin
            if ((IDX > ins_idx) && (IDX <= len_ext)) begin
               cell_in[i] = cell_ff[PREV];
            end else if (IDX == ins_idx) begin
               cell_in[i] = req_ff.value;
            end
         end else if (cmd.exec && do_del) begin
            if ((IDX >= del_idx) && (IDX1 < len_ext)) begin
               cell_in[i] = cell_ff[NEXT];
            end
         end else if (cmd.step) begin
            if (IDX1 < len_ext) begin
               cell_in[i] = cell_ff[NEXT];
            end else if (IDX1 == len_ext) begin
               cell_in[i] = cell_ff[0];
            end
         end
      end

      always_ff @(posedge clock) begin
         cell_ff[i] <= cell_in[i];
      end
   end

   // response register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (exec_load) begin
         rsp_in.status  = exec_status;
         rsp_in.element = '0;
         rsp_in.count   = 5'(len_in);
         rsp_in.last    = 1'b1;
         rsp_valid_in   = 1'b1;
      end else if (cmd.step) begin
         rsp_in.status  = ST_OK;
         rsp_in.element = cell_ff[0];
         rsp_in.count   = 5'(len_ff);
         rsp_in.last    = stat.read_last;
         rsp_valid_in   = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         req_ff <= req_data;
      end
      rd_left_ff <= rd_left_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: rtl/positional_list_engine_top.sv
// Top level of the positional list engine: controller plus datapath.
// Depends on ple_pkg, ple_ctrl and ple_datapath.
//
// Keeps a packed list of up to CAPACITY signed 32-bit values in a row of
// shifting cells. One request is worked at a time: it is taken in the idle
// state and executed once the response register is free. An insert or delete
// gives one response with status and new count; a read out of N elements
// gives one element per cycle while the response side does not stall, as the
// cell row rotates, front first with last on the final element (a single
// empty-status response when the list is empty). Opcodes 5 to 7 give no response.
// Stall on the response side holds the sequencer in place; the response
// register lets the next request be taken while a finished one is pending.
// The cells need no clearing after reset; only count and response valid are cleared.
module positional_list_engine_top #(
   parameter int CAPACITY = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ple_pkg::ple_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ple_pkg::ple_rsp_type rsp_data
);
   import ple_pkg::*;

   ple_cmd_type  cmd;
   ple_stat_type stat;

   // sequencing
   ple_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // list storage and response
   ple_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // one request at a time: after an accepted request the input is held off
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while previous still executing");

   // error responses are single, final and carry no element
   a_error_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != ST_OK)) |->
      (rsp_data.last && (rsp_data.element == '0)))
      else $error("error response not final or with element");

   // only read out elements precede the final response
   a_nonlast_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last) |-> (rsp_data.status == ST_OK))
      else $error("non-final response with error status");

   // no new command while the response register is blocked
   a_cmd_blocked: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec || cmd.step) |-> stat.out_free)
      else $error("datapath command issued with response register full");
`endif

endmodule
